@@ rtl/mwcr_pkg.sv @@
// Shared types, register indexes and reset values for the mecanum wheel command ramp.
package mwcr_pkg;

  localparam int NUM_WHEELS  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_RADIUS    = 3'd0,
    REG_HALF_BASE     = 3'd1,
    REG_SPEED_FLOOR   = 3'd2,
    REG_SPEED_CEIL    = 3'd3,
    REG_DECEL_STEP    = 3'd4,
    REG_TIMEOUT_TICKS = 3'd5,
    REG_RAMP_TICKS    = 3'd6
  } reg_idx_t;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } item_t;

  typedef struct packed {
    logic        [15:0] inv_radius;
    logic        [15:0] half_base;
    logic signed [15:0] speed_floor;
    logic signed [15:0] speed_ceil;
    logic        [14:0] decel_step;
    logic        [15:0] timeout_ticks;
    logic        [15:0] ramp_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_radius:    16'd5120,
    half_base:     16'd22938,
    speed_floor:   -16'sd2560,
    speed_ceil:    16'sd2560,
    decel_step:    15'd26,
    timeout_ticks: 16'd100,
    ramp_ticks:    16'd50
  };

endpackage

@@ rtl/mwcr_front.sv @@
// Front end: accepts items, classifies them and buffers them in a short queue.
module mwcr_front #(
  parameter int QueueDepth = mwcr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic signed [15:0]  in_vel_x,
  input  logic signed [15:0]  in_vel_y,
  input  logic signed [15:0]  in_yaw_rate,
  output logic                head_valid,
  output mwcr_pkg::item_t     head_item,
  input  logic                head_pop
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  mwcr_pkg::item_t q_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  mwcr_pkg::item_t item;
  logic            push;
  logic            pop;

  always_comb begin
    if (in_op) begin
      item.kind     = mwcr_pkg::KIND_TICK;
      item.vel_x    = '0;
      item.vel_y    = '0;
      item.yaw_rate = '0;
    end else begin
      item.kind     = mwcr_pkg::KIND_CMD;
      item.vel_x    = in_vel_x;
      item.vel_y    = in_vel_y;
      item.yaw_rate = in_yaw_rate;
    end
  end

  assign in_stall   = (count_r == CntW'(QueueDepth));
  assign head_valid = (count_r != '0);
  assign head_item  = q_r[rd_ptr_r];
  assign push       = in_valid && !in_stall;
  assign pop        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mwcr_back.sv @@
// Back end: kinematics with one shared multiplier, timeout and ramp-down, result register.
module mwcr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mwcr_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  mwcr_pkg::item_t    head_item,
  output logic               head_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_speed_front_left,
  output logic signed [15:0] out_speed_front_right,
  output logic signed [15:0] out_speed_rear_left,
  output logic signed [15:0] out_speed_rear_right,
  output logic               out_ramp_step,
  output logic               out_timer_armed
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YAW,
    S_WL,
    S_MUL,
    S_CLAMP,
    S_TICK,
    S_DONE
  } state_t;

  localparam int WIdxW = $clog2(mwcr_pkg::NUM_WHEELS);

  state_t             state_r;
  mwcr_pkg::item_t    item_r;
  logic [WIdxW-1:0]   idx_r;
  logic signed [35:0] prod_r;
  logic signed [16:0] wl_r;
  logic signed [15:0] wheel_r [mwcr_pkg::NUM_WHEELS];
  logic [15:0]        countdown_r;
  logic               armed_r;
  logic               step_r;
  logic               out_valid_r;
  logic signed [15:0] out_wheel_r [mwcr_pkg::NUM_WHEELS];
  logic               out_step_r;
  logic               out_armed_r;

  logic signed [18:0] sum;
  logic signed [18:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [35:0] prod;
  logic signed [27:0] scaled;
  logic signed [27:0] lo_bound;
  logic signed [27:0] hi_bound;
  logic signed [27:0] low_held;
  logic signed [15:0] clamped;
  logic signed [15:0] dec [mwcr_pkg::NUM_WHEELS];
  logic               any_moving;
  logic               out_free;

  always_comb begin
    case (idx_r)
      2'd0:    sum = 19'(item_r.vel_x) - 19'(item_r.vel_y) - 19'(wl_r);
      2'd1:    sum = 19'(item_r.vel_x) + 19'(item_r.vel_y) + 19'(wl_r);
      2'd2:    sum = 19'(item_r.vel_x) + 19'(item_r.vel_y) - 19'(wl_r);
      default: sum = 19'(item_r.vel_x) - 19'(item_r.vel_y) + 19'(wl_r);
    endcase
  end

  always_comb begin
    if (state_r == S_YAW) begin
      mul_a = 19'(item_r.yaw_rate);
      mul_b = $signed({1'b0, cfg.half_base});
    end else begin
      mul_a = sum;
      mul_b = $signed({1'b0, cfg.inv_radius});
    end
    prod = 36'(mul_a) * 36'(mul_b);
  end

  // Q20.16 -> Q8.8 by floor shift, then clamp min first, max second
  always_comb begin
    scaled   = 28'(prod_r >>> 8);
    lo_bound = 28'(cfg.speed_floor);
    hi_bound = 28'(cfg.speed_ceil);
    low_held = (scaled < lo_bound) ? lo_bound : scaled;
    clamped  = (low_held > hi_bound) ? cfg.speed_ceil : 16'(low_held);
  end

  always_comb begin
    logic signed [16:0] s17;
    logic signed [16:0] mag;
    logic signed [15:0] step16;
    step16     = $signed({1'b0, cfg.decel_step});
    any_moving = 1'b0;
    for (int i = 0; i < mwcr_pkg::NUM_WHEELS; i++) begin
      s17 = 17'(wheel_r[i]);
      mag = (s17 < 0) ? -s17 : s17;
      if ($unsigned(mag) > 17'(cfg.decel_step)) begin
        dec[i] = (wheel_r[i] > 0) ? wheel_r[i] - step16 : wheel_r[i] + step16;
      end else begin
        dec[i] = '0;
      end
      if (dec[i] != '0) begin
        any_moving = 1'b1;
      end
    end
  end

  assign head_pop = (state_r == S_IDLE) && head_valid;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      countdown_r <= '0;
      armed_r     <= 1'b0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mwcr_pkg::NUM_WHEELS; i++) begin
        wheel_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            item_r  <= head_item;
            idx_r   <= '0;
            step_r  <= 1'b0;
            state_r <= (head_item.kind == mwcr_pkg::KIND_CMD) ? S_YAW : S_TICK;
          end
        end
        S_YAW: begin
          prod_r  <= prod;
          state_r <= S_WL;
        end
        S_WL: begin
          wl_r    <= 17'(prod_r >>> 16);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          wheel_r[idx_r] <= clamped;
          if (idx_r == WIdxW'(mwcr_pkg::NUM_WHEELS - 1)) begin
            countdown_r <= cfg.timeout_ticks;
            armed_r     <= 1'b1;
            state_r     <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_TICK: begin
          if (armed_r) begin
            if (countdown_r > 16'd1) begin
              countdown_r <= countdown_r - 1'b1;
            end else begin
              for (int i = 0; i < mwcr_pkg::NUM_WHEELS; i++) begin
                wheel_r[i] <= dec[i];
              end
              step_r      <= 1'b1;
              armed_r     <= any_moving;
              countdown_r <= any_moving ? cfg.ramp_ticks : '0;
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < mwcr_pkg::NUM_WHEELS; i++) begin
              out_wheel_r[i] <= wheel_r[i];
            end
            out_step_r  <= step_r;
            out_armed_r <= armed_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_speed_front_left  = out_wheel_r[0];
  assign out_speed_front_right = out_wheel_r[1];
  assign out_speed_rear_left   = out_wheel_r[2];
  assign out_speed_rear_right  = out_wheel_r[3];
  assign out_ramp_step         = out_step_r;
  assign out_timer_armed       = out_armed_r;

  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> countdown_r == '0)
    else $error("countdown nonzero while disarmed");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> state_r == S_IDLE && head_valid)
    else $error("queue popped while busy");

  a_cmd_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && item_r.kind == mwcr_pkg::KIND_CMD) |-> armed_r && !step_r)
    else $error("command finished without arming");

  a_step_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && step_r) |-> item_r.kind == mwcr_pkg::KIND_TICK)
    else $error("ramp step on a command");

endmodule

@@ rtl/mecanum_wheel_command_ramp.sv @@
// Top level: configuration registers, front queue and execution back end.
// The back end takes a new item from the queue only while idle, so items run one at a time;
// its single shared multiplier runs five products per command in turn.
// Reset (rst_n low, synchronous): registers take their defaults, wheels zero, timer disarmed.
module mecanum_wheel_command_ramp #(
  parameter int QueueDepth = mwcr_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic signed [15:0]                  in_vel_x,
  input  logic signed [15:0]                  in_vel_y,
  input  logic signed [15:0]                  in_yaw_rate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_speed_front_left,
  output logic signed [15:0]                  out_speed_front_right,
  output logic signed [15:0]                  out_speed_rear_left,
  output logic signed [15:0]                  out_speed_rear_right,
  output logic                                out_ramp_step,
  output logic                                out_timer_armed,
  input  logic                                cfg_wr_en,
  input  logic [mwcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mwcr_pkg::cfg_t  cfg_r;
  logic            head_valid;
  mwcr_pkg::item_t head_item;
  logic            head_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mwcr_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mwcr_pkg::REG_INV_RADIUS:    cfg_r.inv_radius    <= cfg_data;
        mwcr_pkg::REG_HALF_BASE:     cfg_r.half_base     <= cfg_data;
        mwcr_pkg::REG_SPEED_FLOOR:   cfg_r.speed_floor   <= $signed(cfg_data);
        mwcr_pkg::REG_SPEED_CEIL:    cfg_r.speed_ceil    <= $signed(cfg_data);
        mwcr_pkg::REG_DECEL_STEP:    cfg_r.decel_step    <= cfg_data[14:0];
        mwcr_pkg::REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
        mwcr_pkg::REG_RAMP_TICKS:    cfg_r.ramp_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  mwcr_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_vel_x    (in_vel_x),
    .in_vel_y    (in_vel_y),
    .in_yaw_rate (in_yaw_rate),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .head_pop    (head_pop)
  );

  mwcr_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .head_valid            (head_valid),
    .head_item             (head_item),
    .head_pop              (head_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_speed_front_left  (out_speed_front_left),
    .out_speed_front_right (out_speed_front_right),
    .out_speed_rear_left   (out_speed_rear_left),
    .out_speed_rear_right  (out_speed_rear_right),
    .out_ramp_step         (out_ramp_step),
    .out_timer_armed       (out_timer_armed)
  );

endmodule
